@@ sv/lts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants for largest_transformed_size
// Field widths, register indexes, result kinds and the divider lane record.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int FIELD_W   = 24;              // Q16.8 bound and result fields
    localparam int COEF_W    = 24;              // Q8.16 matrix coefficients
    localparam int PROD_W    = 2 * FIELD_W;     // one 24x24 product
    localparam int WIDE_W    = 3 * FIELD_W;     // 24 x 48 product
    localparam int QFRAC     = 16;              // coefficient fraction bits
    localparam int Q_W       = FIELD_W + 1;     // quotient plus saturation bit
    localparam int REM_W     = PROD_W + FIELD_W;
    localparam int PRE_STG   = 6;               // stages ahead of the divider
    localparam int N_STG     = PRE_STG + Q_W + 1;
    localparam int IDX_W     = 2;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COEF_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_COEF_C = 2'd2;
    localparam logic [IDX_W-1:0] REG_COEF_D = 2'd3;

    localparam logic [COEF_W-1:0] COEF_ONE  = 24'd65536;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_INF,
        KIND_DIV
    } t_kind;

    // One divider lane: partial remainder, divisor and quotient so far
    typedef struct packed {
        t_kind            kind;
        logic [REM_W-1:0] rem;
        logic [PROD_W-1:0] den;
        logic [Q_W-1:0]   q;
    } t_lane;

    // Bounds of one item after the unbounded side is copied
    typedef struct packed {
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               uw;
        logic               uh;
    } t_item;

endpackage

@@ sv/largest_transformed_size.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_transformed_size: largest pre-transform size fitting a bound pair
// Pipelined evaluation of the fitting size under the 2x2 part of a transform.
// ----------------------------------------------------------------------------
// One item enters per clock while the output side keeps up. Six stages form
// the products, comparisons and the case selection; the rest is a 25-step
// restoring divider, one quotient bit per stage and two lanes (width and
// height), followed by an output register. Each stage holds its item while
// the stage after it is full and stalled, so empty stages close up and new
// items are taken while a result waits. Write the coefficients only while no
// item is in flight; an item may follow on the next cycle.
module largest_transformed_size
    import lts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_idx,
    input  logic [COEF_W-1:0]      i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [23:0] bound_width, [47:24] bound_height
    input  logic [2*FIELD_W-1:0]   i_s_axis_tdata,
    // [0] width_unbounded, [1] height_unbounded
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [23:0] fit_width, [47:24] fit_height
    output logic [2*FIELD_W-1:0]   o_m_axis_tdata,
    // [0] width_infinite, [1] height_infinite
    output logic [1:0]             o_m_axis_tuser
);

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= COEF_ONE;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= COEF_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_A: r_coef_a <= i_cfg_data;
                REG_COEF_B: r_coef_b <= i_cfg_data;
                REG_COEF_C: r_coef_c <= i_cfg_data;
                REG_COEF_D: r_coef_d <= i_cfg_data;
            endcase
        end
    end

    // Magnitudes and zero flags
    logic [COEF_W-1:0] m_a, m_b, m_c, m_d;
    logic              a_zero, b_zero, c_zero, d_zero;

    assign m_a = r_coef_a[COEF_W-1] ? COEF_W'(-r_coef_a) : COEF_W'(r_coef_a);
    assign m_b = r_coef_b[COEF_W-1] ? COEF_W'(-r_coef_b) : COEF_W'(r_coef_b);
    assign m_c = r_coef_c[COEF_W-1] ? COEF_W'(-r_coef_c) : COEF_W'(r_coef_c);
    assign m_d = r_coef_d[COEF_W-1] ? COEF_W'(-r_coef_d) : COEF_W'(r_coef_d);
    assign a_zero = (r_coef_a == '0);
    assign b_zero = (r_coef_b == '0);
    assign c_zero = (r_coef_c == '0);
    assign d_zero = (r_coef_d == '0);

    // Derived coefficient terms: the products are registered, then the sums, differences and flags
    logic [PROD_W-1:0] r_ad, r_bc, r_ac, r_bd;
    logic              r_ad_neg, r_bc_neg;
    logic [PROD_W-1:0] r_s, r_ac2, r_bd2, r_gden_mag;
    logic              r_gden_neg, r_gden_zero, r_det_zero;

    always_ff @(posedge i_clk) begin
        r_ad     <= m_a * m_d;
        r_bc     <= m_b * m_c;
        r_ac     <= m_a * m_c;
        r_bd     <= m_b * m_d;
        r_ad_neg <= r_coef_a[COEF_W-1] ^ r_coef_d[COEF_W-1];
        r_bc_neg <= r_coef_b[COEF_W-1] ^ r_coef_c[COEF_W-1];
    end

    always_ff @(posedge i_clk) begin
        r_s         <= r_ad + r_bc;
        r_ac2       <= {r_ac[PROD_W-2:0], 1'b0};
        r_bd2       <= {r_bd[PROD_W-2:0], 1'b0};
        r_gden_neg  <= (r_ad < r_bc);
        r_gden_mag  <= (r_ad < r_bc) ? (r_bc - r_ad) : (r_ad - r_bc);
        r_gden_zero <= (r_ad == r_bc);
        r_det_zero  <= (r_ad == r_bc) && ((r_ad == '0) || (r_ad_neg == r_bc_neg));
    end

    // ------------------------------------------------------------------
    // Stage valids and the hold chain
    // ------------------------------------------------------------------
    logic [N_STG:1]   r_v;
    logic [N_STG+1:1] en;

    always_comb begin
        en[N_STG+1] = i_m_axis_tready;
        for (int k = N_STG; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[1] && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= N_STG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the bounds, copy an unbounded side
    // ------------------------------------------------------------------
    t_item              r1_it;
    logic               r1_both;
    logic [FIELD_W-1:0] in_w, in_h, cp_w;

    assign in_w = i_s_axis_tdata[FIELD_W-1:0];
    assign in_h = i_s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign cp_w = i_s_axis_tuser[0] ? in_h : in_w;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_it.w  <= cp_w;
            r1_it.h  <= i_s_axis_tuser[1] ? cp_w : in_h;
            r1_it.uw <= i_s_axis_tuser[0];
            r1_it.uh <= i_s_axis_tuser[1];
            r1_both  <= i_s_axis_tuser[0] && i_s_axis_tuser[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: limit-line products
    // ------------------------------------------------------------------
    t_item             r2_it;
    logic              r2_both;
    logic [PROD_W-1:0] r2_wd, r2_ch, r2_ah, r2_bw;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_it   <= r1_it;
            r2_both <= r1_both;
            r2_wd   <= r1_it.w * m_d;
            r2_ch   <= m_c * r1_it.h;
            r2_ah   <= m_a * r1_it.h;
            r2_bw   <= m_b * r1_it.w;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: partial products of the midpoint tests, line differences
    // ------------------------------------------------------------------
    t_item                    r3_it;
    logic                     r3_both;
    logic [PROD_W-1:0]        r3_wd, r3_ch, r3_ah, r3_bw;
    logic [PROD_W-1:0]        r3_ws_lo, r3_ws_hi, r3_hac_lo, r3_hac_hi;
    logic [PROD_W-1:0]        r3_hs_lo, r3_hs_hi, r3_wbd_lo, r3_wbd_hi;
    logic signed [PROD_W:0]   r3_diff1, r3_diff2;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_it     <= r2_it;
            r3_both   <= r2_both;
            r3_wd     <= r2_wd;
            r3_ch     <= r2_ch;
            r3_ah     <= r2_ah;
            r3_bw     <= r2_bw;
            r3_ws_lo  <= r2_it.w * r_s[FIELD_W-1:0];
            r3_ws_hi  <= r2_it.w * r_s[PROD_W-1:FIELD_W];
            r3_hac_lo <= r2_it.h * r_ac2[FIELD_W-1:0];
            r3_hac_hi <= r2_it.h * r_ac2[PROD_W-1:FIELD_W];
            r3_hs_lo  <= r2_it.h * r_s[FIELD_W-1:0];
            r3_hs_hi  <= r2_it.h * r_s[PROD_W-1:FIELD_W];
            r3_wbd_lo <= r2_it.w * r_bd2[FIELD_W-1:0];
            r3_wbd_hi <= r2_it.w * r_bd2[PROD_W-1:FIELD_W];
            r3_diff1  <= $signed({1'b0, r2_wd}) - $signed({1'b0, r2_ch});
            r3_diff2  <= $signed({1'b0, r2_ah}) - $signed({1'b0, r2_bw});
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: assemble wide products, rotation-case tests
    // ------------------------------------------------------------------
    t_item                  r4_it;
    logic                   r4_both;
    logic [WIDE_W-1:0]      r4_ws, r4_hac, r4_hs, r4_wbd;
    logic signed [PROD_W:0] r4_diff1, r4_diff2;
    logic                   r4_c2, r4_c3, r4_c5, r4_c6;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_it    <= r3_it;
            r4_both  <= r3_both;
            r4_ws    <= WIDE_W'(r3_ws_lo)  + {r3_ws_hi,  {FIELD_W{1'b0}}};
            r4_hac   <= WIDE_W'(r3_hac_lo) + {r3_hac_hi, {FIELD_W{1'b0}}};
            r4_hs    <= WIDE_W'(r3_hs_lo)  + {r3_hs_hi,  {FIELD_W{1'b0}}};
            r4_wbd   <= WIDE_W'(r3_wbd_lo) + {r3_wbd_hi, {FIELD_W{1'b0}}};
            r4_diff1 <= r3_diff1;
            r4_diff2 <= r3_diff2;
            r4_c2    <= ({1'b0, r3_wd} <= {r3_ch, 1'b0});
            r4_c3    <= ({1'b0, r3_ah} <= {r3_bw, 1'b0});
            r4_c5    <= ({1'b0, r3_ch} <= {r3_wd, 1'b0});
            r4_c6    <= ({1'b0, r3_bw} <= {r3_ah, 1'b0});
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: midpoint tests of the general case
    // ------------------------------------------------------------------
    t_item                  r5_it;
    logic                   r5_both;
    logic signed [PROD_W:0] r5_diff1, r5_diff2;
    logic                   r5_c2, r5_c3, r5_c5, r5_c6, r5_g1, r5_g2;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_it    <= r4_it;
            r5_both  <= r4_both;
            r5_diff1 <= r4_diff1;
            r5_diff2 <= r4_diff2;
            r5_c2    <= r4_c2;
            r5_c3    <= r4_c3;
            r5_c5    <= r4_c5;
            r5_c6    <= r4_c6;
            r5_g1    <= (r4_ws <= r4_hac);
            r5_g2    <= (r4_hs <= r4_wbd);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pick dividend and divisor of each lane
    // ------------------------------------------------------------------
    function automatic t_lane mk_div(input logic [PROD_W-1:0] n,
                                     input logic [PROD_W-1:0] d);
        t_lane l;
        l.kind = KIND_DIV;
        l.rem  = {{(REM_W-PROD_W-QFRAC){1'b0}}, n, {QFRAC{1'b0}}};
        l.den  = d;
        l.q    = '0;
        return l;
    endfunction

    function automatic t_lane mk_const(input t_kind k);
        t_lane l;
        l.kind = k;
        l.rem  = '0;
        l.den  = '0;
        l.q    = '0;
        return l;
    endfunction

    // Signed quotient: zero unless both sides share a strict sign
    function automatic t_lane mk_sdiv(input logic signed [PROD_W:0] n,
                                      input logic [PROD_W-1:0] dmag,
                                      input logic dneg, input logic dzero);
        logic [PROD_W:0] nmag;
        nmag = n[PROD_W] ? (PROD_W+1)'(-n) : (PROD_W+1)'(n);
        if (dzero || (n == '0) || (n[PROD_W] != dneg)) begin
            return mk_const(KIND_ZERO);
        end
        return mk_div(nmag[PROD_W-1:0], dmag);
    endfunction

    logic [PROD_W-1:0] x_w, x_h, x_a, x_b, x_c, x_d;
    logic [PROD_W-1:0] x_a2, x_b2, x_c2, x_d2;
    logic [PROD_W-1:0] x_d1m, x_d2m, x_d1n, x_d2n;
    logic              empty;
    t_lane             sel_w, sel_h, r6_w, r6_h;
    t_lane             inf_l;

    assign x_w   = PROD_W'(r5_it.w);
    assign x_h   = PROD_W'(r5_it.h);
    assign x_a   = PROD_W'(m_a);
    assign x_b   = PROD_W'(m_b);
    assign x_c   = PROD_W'(m_c);
    assign x_d   = PROD_W'(m_d);
    assign x_a2  = PROD_W'({m_a, 1'b0});
    assign x_b2  = PROD_W'({m_b, 1'b0});
    assign x_c2  = PROD_W'({m_c, 1'b0});
    assign x_d2  = PROD_W'({m_d, 1'b0});
    assign x_d1m = r5_diff1[PROD_W-1:0];
    assign x_d2m = r5_diff2[PROD_W-1:0];
    assign x_d1n = PROD_W'(-r5_diff1);
    assign x_d2n = PROD_W'(-r5_diff2);
    assign empty = (r5_it.w == '0) || (r5_it.h == '0) || r_det_zero;
    assign inf_l = mk_const(KIND_INF);

    always_comb begin
        sel_w = mk_const(KIND_ZERO);
        sel_h = mk_const(KIND_ZERO);
        priority if (r5_both) begin
            sel_w = inf_l;
            sel_h = inf_l;
        end else if (empty) begin
            sel_w = mk_const(KIND_ZERO);
            sel_h = mk_const(KIND_ZERO);
        end else if (b_zero && c_zero) begin
            // Plain scale
            sel_w = r5_it.uw ? inf_l : mk_div(x_w, x_a);
            sel_h = r5_it.uh ? inf_l : mk_div(x_h, x_d);
        end else if (b_zero) begin
            if (r5_it.uh || r5_c2) begin
                sel_h = mk_div(x_w, x_c2);
                sel_w = r5_it.uw ? inf_l : mk_div(x_w, x_a2);
            end else begin
                sel_h = mk_div(x_h, x_d);
                sel_w = r5_it.uw ? inf_l : mk_div(x_d1m, r_ad);
            end
        end else if (c_zero) begin
            if (r5_it.uw || r5_c3) begin
                sel_w = mk_div(x_h, x_b2);
                sel_h = r5_it.uh ? inf_l : mk_div(x_h, x_d2);
            end else begin
                sel_w = mk_div(x_w, x_a);
                sel_h = r5_it.uh ? inf_l : mk_div(x_d2m, r_ad);
            end
        end else if (a_zero && d_zero) begin
            // Quarter turn: sides swap
            sel_w = r5_it.uh ? inf_l : mk_div(x_h, x_b);
            sel_h = r5_it.uw ? inf_l : mk_div(x_w, x_c);
        end else if (a_zero) begin
            if (r5_it.uw || r5_c5) begin
                sel_h = mk_div(x_h, x_d2);
                sel_w = r5_it.uh ? inf_l : mk_div(x_h, x_b2);
            end else begin
                sel_h = mk_div(x_w, x_c);
                sel_w = r5_it.uh ? inf_l : mk_div(x_d1n, r_bc);
            end
        end else if (d_zero) begin
            if (r5_it.uh || r5_c6) begin
                sel_w = mk_div(x_w, x_a2);
                sel_h = r5_it.uw ? inf_l : mk_div(x_w, x_c2);
            end else begin
                sel_w = mk_div(x_h, x_b);
                sel_h = r5_it.uw ? inf_l : mk_div(x_d2n, r_bc);
            end
        end else if (r5_g1) begin
            // Midpoint of the width line
            sel_w = mk_div(x_w, x_a2);
            sel_h = mk_div(x_w, x_c2);
        end else if (r5_g2) begin
            // Midpoint of the height line
            sel_w = mk_div(x_h, x_b2);
            sel_h = mk_div(x_h, x_d2);
        end else begin
            // Crossing point of the two limit lines
            sel_w = mk_sdiv(r5_diff1, r_gden_mag, r_gden_neg, r_gden_zero);
            sel_h = mk_sdiv(r5_diff2, r_gden_mag, r_gden_neg, r_gden_zero);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[PRE_STG]) begin
            r6_w <= sel_w;
            r6_h <= sel_h;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, top bit flags saturation
    // ------------------------------------------------------------------
    function automatic t_lane div_step(input t_lane x, input int b);
        t_lane            y;
        logic [REM_W-1:0] sh;
        y  = x;
        sh = REM_W'(x.den) << b;
        if (x.rem >= sh) begin
            y.rem  = x.rem - sh;
            y.q[b] = 1'b1;
        end
        return y;
    endfunction

    t_lane r_dw [Q_W];
    t_lane r_dh [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        t_lane pw, ph;
        if (j == 0) begin : g_first
            assign pw = r6_w;
            assign ph = r6_h;
        end else begin : g_next
            assign pw = r_dw[j-1];
            assign ph = r_dh[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (en[PRE_STG+1+j]) begin
                r_dw[j] <= div_step(pw, Q_W-1-j);
                r_dh[j] <= div_step(ph, Q_W-1-j);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate and flag infinite sides
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] lane_value(input t_lane l);
        if (l.kind == KIND_INF) return FIELD_MAX;
        if (l.kind == KIND_ZERO) return '0;
        return l.q[Q_W-1] ? FIELD_MAX : l.q[FIELD_W-1:0];
    endfunction

    logic [2*FIELD_W-1:0] r_out_data;
    logic [1:0]           r_out_user;

    always_ff @(posedge i_clk) begin
        if (en[N_STG]) begin
            r_out_data <= {lane_value(r_dh[Q_W-1]), lane_value(r_dw[Q_W-1])};
            r_out_user <= {r_dh[Q_W-1].kind == KIND_INF, r_dw[Q_W-1].kind == KIND_INF};
        end
    end

    assign o_m_axis_tvalid = r_v[N_STG];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

@@ sv/lts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_checker: port-level checks for largest_transformed_size
// Output stream behavior and result flag consistency.
// ----------------------------------------------------------------------------
module lts_checker
    import lts_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [IDX_W-1:0]     i_cfg_idx,
    input logic [COEF_W-1:0]    i_cfg_data,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [2*FIELD_W-1:0] i_s_axis_tdata,
    input logic [1:0]           i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [2*FIELD_W-1:0] o_m_axis_tdata,
    input logic [1:0]           o_m_axis_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // An infinite width reads as full scale
    a_inf_w: assert property (@(posedge i_clk)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[FIELD_W-1:0] == FIELD_MAX)
        else $error("infinite width not full scale");

    // An infinite height reads as full scale
    a_inf_h: assert property (@(posedge i_clk)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            o_m_axis_tdata[2*FIELD_W-1:FIELD_W] == FIELD_MAX)
        else $error("infinite height not full scale");

    // Drop all items in reset; take none
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result after reset");

    a_no_take: assert property (@(posedge i_clk)
        !i_rst_n |-> !o_s_axis_tready)
        else $error("ready during reset");

endmodule

bind largest_transformed_size lts_checker u_lts_checker (.*);

@@ tb/tb_largest_transformed_size.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_largest_transformed_size: self-checking bench for the fitting-size block
// Runs directed bound pairs and then random ones under several coefficient
// sets. Each result is compared against an in-bench exact-arithmetic
// predictor. Both sides idle at random, and the output side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_largest_transformed_size;
    import lts_pkg::*;

    localparam int  LATENCY   = 40;
    localparam int  CYCLE_CAP = 2000000;
    localparam int  N_RANDOM  = 1500;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [2*FIELD_W-1:0] i_s_axis_tdata = '0;
    logic [1:0]           i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [2*FIELD_W-1:0] o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;

    typedef struct packed {
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               iw;
        logic               ih;
    } t_fit;

    typedef struct {
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               uw;
        logic               uh;
        logic               known;
        t_fit               fit;
    } t_row;

    t_fit                 fit_queue[$];
    logic signed [23:0]   coef[4];
    int                   fail_count = 0;
    int                   cycle_count = 0;
    bit                   calm = 1'b0;
    bit                   hold_req = 1'b0;

    always #2 i_clk = ~i_clk;

    largest_transformed_size dut (.*);

    // Exact quotient n*65536/den, truncated and saturated
    function automatic logic [FIELD_W-1:0] fit_div(logic [127:0] n, logic [127:0] den);
        logic [127:0] v;
        if (den == 0) return FIELD_MAX;
        v = (n << 16) / den;
        return (v > FIELD_MAX) ? FIELD_MAX : v[FIELD_W-1:0];
    endfunction

    function automatic t_fit fit_of(logic [FIELD_W-1:0] bw, logic [FIELD_W-1:0] bh,
                                    logic uw, logic uh);
        t_fit r;
        longint sa, sb, sc, sd, den, nw, nh;
        logic [127:0] W, H, A, B, C, D, s;
        sa = coef[0]; sb = coef[1]; sc = coef[2]; sd = coef[3];
        A = (sa < 0) ? -sa : sa; B = (sb < 0) ? -sb : sb;
        C = (sc < 0) ? -sc : sc; D = (sd < 0) ? -sd : sd;
        W = bw; H = bh;
        r = '0;
        if (uw && uh) begin
            r.iw = 1'b1; r.ih = 1'b1;
        end else begin
            if (uw) W = H;
            if (uh) H = W;
            if (W == 0 || H == 0 || sa * sd - sb * sc == 0) begin
                // empty bound or singular matrix
            end else if (B == 0 && C == 0) begin
                if (uw) r.iw = 1'b1; else r.w = fit_div(W, A);
                if (uh) r.ih = 1'b1; else r.h = fit_div(H, D);
            end else if (B == 0) begin
                if (uh || W * D <= 2 * C * H) begin
                    r.h = fit_div(W, 2 * C);
                    if (uw) r.iw = 1'b1; else r.w = fit_div(W, 2 * A);
                end else begin
                    r.h = fit_div(H, D);
                    if (uw) r.iw = 1'b1; else r.w = fit_div(W * D - C * H, A * D);
                end
            end else if (C == 0) begin
                if (uw || H * A <= 2 * B * W) begin
                    r.w = fit_div(H, 2 * B);
                    if (uh) r.ih = 1'b1; else r.h = fit_div(H, 2 * D);
                end else begin
                    r.w = fit_div(W, A);
                    if (uh) r.ih = 1'b1; else r.h = fit_div(H * A - B * W, A * D);
                end
            end else if (A == 0 && D == 0) begin
                if (uh) r.iw = 1'b1; else r.w = fit_div(H, B);
                if (uw) r.ih = 1'b1; else r.h = fit_div(W, C);
            end else if (A == 0) begin
                if (uw || H * C <= 2 * D * W) begin
                    r.h = fit_div(H, 2 * D);
                    if (uh) r.iw = 1'b1; else r.w = fit_div(H, 2 * B);
                end else begin
                    r.h = fit_div(W, C);
                    if (uh) r.iw = 1'b1; else r.w = fit_div(H * C - D * W, B * C);
                end
            end else if (D == 0) begin
                if (uh || W * B <= 2 * A * H) begin
                    r.w = fit_div(W, 2 * A);
                    if (uw) r.ih = 1'b1; else r.h = fit_div(W, 2 * C);
                end else begin
                    r.w = fit_div(H, B);
                    if (uw) r.ih = 1'b1; else r.h = fit_div(W * B - A * H, B * C);
                end
            end else begin
                s = A * D + B * C;
                if (W * s <= 2 * A * C * H) begin
                    r.w = fit_div(W, 2 * A); r.h = fit_div(W, 2 * C);
                end else if (H * s <= 2 * B * D * W) begin
                    r.w = fit_div(H, 2 * B); r.h = fit_div(H, 2 * D);
                end else begin
                    // crossing point; negative or parallel gives zero
                    den = longint'(A * D) - longint'(B * C);
                    nw = longint'(W * D) - longint'(C * H);
                    nh = longint'(A * H) - longint'(B * W);
                    if (den != 0 && nw != 0 && ((nw < 0) == (den < 0)))
                        r.w = fit_div((nw < 0) ? -nw : nw, (den < 0) ? -den : den);
                    if (den != 0 && nh != 0 && ((nh < 0) == (den < 0)))
                        r.h = fit_div((nh < 0) ? -nh : nh, (den < 0) ? -den : den);
                end
            end
        end
        if (r.iw) r.w = FIELD_MAX;
        if (r.ih) r.h = FIELD_MAX;
        return r;
    endfunction

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: random stalls, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 18);
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_fit got, exp_fit;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[23:0], o_m_axis_tdata[47:24],
                   o_m_axis_tuser[0], o_m_axis_tuser[1]};
            if (fit_queue.size() == 0) begin
                $error("unexpected result %h", got);
                fail_count++;
            end else begin
                exp_fit = fit_queue.pop_front();
                if (got.w !== exp_fit.w) begin
                    $error("fit_width exp %h got %h", exp_fit.w, got.w); fail_count++;
                end
                if (got.h !== exp_fit.h) begin
                    $error("fit_height exp %h got %h", exp_fit.h, got.h); fail_count++;
                end
                if (got.iw !== exp_fit.iw) begin
                    $error("width_infinite exp %b got %b", exp_fit.iw, got.iw);
                    fail_count++;
                end
                if (got.ih !== exp_fit.ih) begin
                    $error("height_infinite exp %b got %b", exp_fit.ih, got.ih);
                    fail_count++;
                end
            end
        end
    end

    // Drive one register write; the caller drops the enable after the last
    task automatic write_coef(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] v);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        coef[idx] = v;
        @(posedge i_clk);
    endtask

    task automatic set_matrix(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                              logic [23:0] d);
        i_s_axis_tvalid <= 1'b0;
        wait (fit_queue.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
        write_coef(REG_COEF_A, a); write_coef(REG_COEF_B, b);
        write_coef(REG_COEF_C, c); write_coef(REG_COEF_D, d);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one item; hold it until taken
    task automatic send_bounds(t_row row);
        int n;
        t_fit e;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 18);
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        e = fit_of(row.w, row.h, row.uw, row.uh);
        if (row.known && e !== row.fit) begin
            $error("table row exp %h predictor %h", row.fit, e);
            fail_count++;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {row.h, row.w};
        i_s_axis_tuser  <= {row.uh, row.uw};
        do @(posedge i_clk); while (!o_s_axis_tready);
        fit_queue.push_back(row.known ? row.fit : e);
    endtask

    function automatic logic [23:0] rnd_field();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return 24'hFFFFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 24'h3FFF);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [23:0] rnd_coef();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'h800000;
            2: return 24'h7FFFFF;
            3: return $urandom_range(1, 4);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_row tbl[$];
        t_row row;
        coef[0] = COEF_ONE; coef[1] = 0; coef[2] = 0; coef[3] = COEF_ONE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at reset identity: extremes and special cases
        tbl.push_back('{24'h000100, 24'h000200, 0, 0, 1, '{24'h000100, 24'h000200, 0, 0}});
        tbl.push_back('{24'hFFFFFF, 24'hFFFFFF, 0, 0, 1, '{24'hFFFFFF, 24'hFFFFFF, 0, 0}});
        tbl.push_back('{24'h000000, 24'h000500, 0, 0, 1, '{0, 0, 0, 0}});
        tbl.push_back('{24'h000500, 24'h000000, 0, 0, 1, '{0, 0, 0, 0}});
        tbl.push_back('{24'h000123, 24'h000456, 1, 1, 1, '{24'hFFFFFF, 24'hFFFFFF, 1, 1}});
        tbl.push_back('{24'h000000, 24'h000300, 1, 0, 1, '{24'hFFFFFF, 24'h000300, 1, 0}});
        tbl.push_back('{24'h000300, 24'h000000, 0, 1, 1, '{24'h000300, 24'hFFFFFF, 0, 1}});
        tbl.push_back('{24'h000001, 24'h000001, 0, 0, 1, '{24'h000001, 24'h000001, 0, 0}});
        foreach (tbl[i]) send_bounds(tbl[i]);

        // Singular matrix
        set_matrix(24'h010000, 24'h020000, 24'h008000, 24'h010000);
        tbl = {};
        tbl.push_back('{24'h001000, 24'h001000, 0, 0, 1, '{0, 0, 0, 0}});
        tbl.push_back('{24'hFFFFFF, 24'h000001, 0, 1, 1, '{0, 0, 0, 0}});
        foreach (tbl[i]) send_bounds(tbl[i]);

        // Rotations and two other matrices, predictor checked
        for (int m = 0; m < 4; m++) begin
            case (m)
                0: set_matrix(24'h000000, 24'h010000, 24'hFF0000, 24'h000000);
                1: set_matrix(24'hFF0000, 24'h000000, 24'h004000, 24'h020000);
                2: set_matrix(24'h00B505, 24'hFF4AFB, 24'h00B505, 24'h00B505);
                default: set_matrix(24'h000000, 24'h008000, 24'h020000, 24'h000001);
            endcase
            for (int k = 0; k < 4; k++) begin
                row = '{$urandom_range(0, 24'hFFFF), $urandom_range(0, 24'hFFFF),
                        k[0], k[1] & ~k[0], 0, '0};
                send_bounds(row);
            end
        end

        // Random part across random matrices, including extremes
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 150 == 0) begin
                if (i == 300) set_matrix(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
                else if (i == 450) set_matrix(24'h000001, 24'h000001, 24'hFFFFFF, 24'h000001);
                else set_matrix(rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef());
            end
            if (i == 600) hold_req = 1'b1;
            if (i == N_RANDOM - 200) calm = 1'b1;
            row.w = rnd_field(); row.h = rnd_field();
            row.uw = ($urandom_range(0, 5) == 0);
            row.uh = ($urandom_range(0, 5) == 0);
            row.known = 0;
            send_bounds(row);
        end

        // Drain
        i_s_axis_tvalid <= 1'b0;
        wait (fit_queue.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
